// ----- sv/lpstv_pkg.sv -----
// shared types, constants and the cordic step table for the stv calculator
`default_nettype none
package lpstv_pkg;

    // default component width and default selected particle code
    localparam int MOMENTUM_BITS_DEF = 16;
    localparam logic signed [31:0] DEFAULT_CODE = 32'sd2212;

    // one closed event handed from the front to the back
    typedef struct packed {
        logic signed [15:0] mu_x;
        logic signed [15:0] mu_y;
        logic signed [15:0] mu_z;
        logic signed [15:0] ld_x;
        logic signed [15:0] ld_y;
        logic signed [15:0] ld_z;
        logic               found;
    } evt_t;

    // arctangent of 2^-i, scaled so that 32768 is pi
    function automatic logic [13:0] step_angle(input logic [3:0] idx);
        logic [13:0] a;
        case (idx)
            4'd0:    a = 14'd8192;
            4'd1:    a = 14'd4836;
            4'd2:    a = 14'd2555;
            4'd3:    a = 14'd1297;
            4'd4:    a = 14'd651;
            4'd5:    a = 14'd326;
            4'd6:    a = 14'd163;
            4'd7:    a = 14'd81;
            4'd8:    a = 14'd41;
            4'd9:    a = 14'd20;
            4'd10:   a = 14'd10;
            4'd11:   a = 14'd5;
            4'd12:   a = 14'd3;
            4'd13:   a = 14'd1;
            4'd14:   a = 14'd1;
            default: a = 14'd0;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

// ----- sv/lpstv_front.sv -----
// front end: takes words, tracks the leading particle and closes events
`default_nettype none
module lpstv_front
    import lpstv_pkg::*;
#(
    parameter int MOMENTUM_BITS = MOMENTUM_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic signed [31:0] cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               mode,
    input  logic signed [31:0] pdg_code,
    input  logic signed [15:0] mom_x,
    input  logic signed [15:0] mom_y,
    input  logic signed [15:0] mom_z,
    input  logic               last,
    output logic               push_valid,
    input  logic               push_ready,
    output evt_t               push_data
);

    localparam int COMP_W = (MOMENTUM_BITS < 16) ? MOMENTUM_BITS : 16;

    logic signed [31:0] code_reg;

    // first stage: captured word
    logic               s1_vld_reg;
    logic               s1_mode_reg;
    logic               s1_match_reg;
    logic               s1_last_reg;
    logic signed [15:0] s1_x_reg;
    logic signed [15:0] s1_y_reg;
    logic signed [15:0] s1_z_reg;

    // second stage: word plus squared components
    logic               s2_vld_reg;
    logic               s2_mode_reg;
    logic               s2_match_reg;
    logic               s2_last_reg;
    logic signed [15:0] s2_x_reg;
    logic signed [15:0] s2_y_reg;
    logic signed [15:0] s2_z_reg;
    logic [31:0]        s2_sqx_reg;
    logic [31:0]        s2_sqy_reg;
    logic [31:0]        s2_sqz_reg;

    // event accumulation
    logic signed [15:0] mu_x_reg;
    logic signed [15:0] mu_y_reg;
    logic signed [15:0] mu_z_reg;
    logic signed [15:0] ld_x_reg;
    logic signed [15:0] ld_y_reg;
    logic signed [15:0] ld_z_reg;
    logic [31:0]        best_reg;
    logic               seen_reg;
    logic               first_reg;

    logic               s1_adv;
    logic               s2_go;
    logic               accept;
    logic [31:0]        msq;
    logic signed [15:0] mu_x_next;
    logic signed [15:0] mu_y_next;
    logic signed [15:0] mu_z_next;
    logic signed [15:0] ld_x_next;
    logic signed [15:0] ld_y_next;
    logic signed [15:0] ld_z_next;
    logic [31:0]        best_next;
    logic               seen_next;
    logic               first_next;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic signed [15:0] cz;

    // pipeline flow
    assign s2_go    = s2_vld_reg && (!s2_last_reg || push_ready);
    assign s1_adv   = s1_vld_reg && (!s2_vld_reg || s2_go);
    assign in_stall = s1_vld_reg && !s1_adv;
    assign accept   = in_valid && !in_stall;

    // components are the low bits of each field, sign extended
    assign cx = 16'($signed(mom_x[COMP_W-1:0]));
    assign cy = 16'($signed(mom_y[COMP_W-1:0]));
    assign cz = 16'($signed(mom_z[COMP_W-1:0]));

    // muon capture and running maximum update for the word in the second stage
    always_comb
    begin
        msq        = 32'(s2_sqx_reg + s2_sqy_reg + s2_sqz_reg);
        mu_x_next  = mu_x_reg;
        mu_y_next  = mu_y_reg;
        mu_z_next  = mu_z_reg;
        ld_x_next  = ld_x_reg;
        ld_y_next  = ld_y_reg;
        ld_z_next  = ld_z_reg;
        best_next  = best_reg;
        seen_next  = seen_reg;
        first_next = first_reg;
        if (!s2_mode_reg)
        begin
            mu_x_next  = s2_x_reg;
            mu_y_next  = s2_y_reg;
            mu_z_next  = s2_z_reg;
            ld_x_next  = '0;
            ld_y_next  = '0;
            ld_z_next  = '0;
            best_next  = '0;
            seen_next  = 1'b0;
            first_next = 1'b1;
        end
        else
        begin
            if (first_reg)
            begin
                ld_x_next  = s2_x_reg;
                ld_y_next  = s2_y_reg;
                ld_z_next  = s2_z_reg;
                first_next = 1'b0;
            end
            if (s2_match_reg)
            begin
                seen_next = 1'b1;
                if (msq > best_reg)
                begin
                    best_next = msq;
                    ld_x_next = s2_x_reg;
                    ld_y_next = s2_y_reg;
                    ld_z_next = s2_z_reg;
                end
            end
        end
    end

    // snapshot of the closing event
    assign push_valid      = s2_vld_reg && s2_last_reg;
    assign push_data.mu_x  = mu_x_next;
    assign push_data.mu_y  = mu_y_next;
    assign push_data.mu_z  = mu_z_next;
    assign push_data.ld_x  = ld_x_next;
    assign push_data.ld_y  = ld_y_next;
    assign push_data.ld_z  = ld_z_next;
    assign push_data.found = seen_next;

    // registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_reg   <= DEFAULT_CODE;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            mu_x_reg   <= '0;
            mu_y_reg   <= '0;
            mu_z_reg   <= '0;
            ld_x_reg   <= '0;
            ld_y_reg   <= '0;
            ld_z_reg   <= '0;
            best_reg   <= '0;
            seen_reg   <= 1'b0;
            first_reg  <= 1'b1;
        end
        else
        begin
            if (cfg_write)
            begin
                code_reg <= cfg_data;
            end

            // first stage
            if (accept)
            begin
                s1_vld_reg   <= 1'b1;
                s1_mode_reg  <= mode;
                s1_match_reg <= (pdg_code == code_reg);
                s1_last_reg  <= last;
                s1_x_reg     <= cx;
                s1_y_reg     <= cy;
                s1_z_reg     <= cz;
            end
            else if (s1_adv)
            begin
                s1_vld_reg <= 1'b0;
            end

            // second stage
            if (s1_adv)
            begin
                s2_vld_reg   <= 1'b1;
                s2_mode_reg  <= s1_mode_reg;
                s2_match_reg <= s1_match_reg;
                s2_last_reg  <= s1_last_reg;
                s2_x_reg     <= s1_x_reg;
                s2_y_reg     <= s1_y_reg;
                s2_z_reg     <= s1_z_reg;
                s2_sqx_reg   <= 32'(s1_x_reg * s1_x_reg);
                s2_sqy_reg   <= 32'(s1_y_reg * s1_y_reg);
                s2_sqz_reg   <= 32'(s1_z_reg * s1_z_reg);
            end
            else if (s2_go)
            begin
                s2_vld_reg <= 1'b0;
            end

            // event state; the leading-particle state is cleared after a closing word
            if (s2_go)
            begin
                mu_x_reg <= mu_x_next;
                mu_y_reg <= mu_y_next;
                mu_z_reg <= mu_z_next;
                if (s2_last_reg)
                begin
                    ld_x_reg  <= '0;
                    ld_y_reg  <= '0;
                    ld_z_reg  <= '0;
                    best_reg  <= '0;
                    seen_reg  <= 1'b0;
                    first_reg <= 1'b1;
                end
                else
                begin
                    ld_x_reg  <= ld_x_next;
                    ld_y_reg  <= ld_y_next;
                    ld_z_reg  <= ld_z_next;
                    best_reg  <= best_next;
                    seen_reg  <= seen_next;
                    first_reg <= first_next;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ----- sv/lpstv_queue.sv -----
// two-entry event queue between front and back
`default_nettype none
module lpstv_queue
    import lpstv_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  evt_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output evt_t pop_data
);

    evt_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

// ----- sv/lpstv_back.sv -----
// back end: sequenced products, square roots, divides and cordic angles
`default_nettype none
module lpstv_back
    import lpstv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               evt_valid,
    output logic               evt_pop,
    input  evt_t               evt_data,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [16:0]        transverse_imbalance,
    output logic [15:0]        phi_t_angle,
    output logic [15:0]        alpha_t_angle,
    output logic               angle_invalid,
    output logic               proton_found,
    output logic [15:0]        proton_magnitude,
    output logic signed [15:0] proton_cos_polar,
    output logic [15:0]        muon_magnitude,
    output logic signed [15:0] muon_cos_polar,
    output logic               polar_invalid
);

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_DISP = 3'd2;
    localparam logic [2:0] ST_SQRT = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_NORM = 3'd5;
    localparam logic [2:0] ST_ROT  = 3'd6;
    localparam logic [2:0] ST_FIN  = 3'd7;

    // jobs in order
    localparam logic [2:0] J_DPT   = 3'd0;
    localparam logic [2:0] J_PMAG  = 3'd1;
    localparam logic [2:0] J_MMAG  = 3'd2;
    localparam logic [2:0] J_PCOS  = 3'd3;
    localparam logic [2:0] J_MCOS  = 3'd4;
    localparam logic [2:0] J_PHI   = 3'd5;
    localparam logic [2:0] J_ALPHA = 3'd6;
    localparam logic [2:0] J_DONE  = 3'd7;

    // accumulator slots
    localparam logic [3:0] A_MUT  = 4'd0;
    localparam logic [3:0] A_MUZ  = 4'd1;
    localparam logic [3:0] A_PT   = 4'd2;
    localparam logic [3:0] A_PZ   = 4'd3;
    localparam logic [3:0] A_DPT  = 4'd4;
    localparam logic [3:0] A_DOT1 = 4'd5;
    localparam logic [3:0] A_CR1  = 4'd6;
    localparam logic [3:0] A_DOT2 = 4'd7;
    localparam logic [3:0] A_CR2  = 4'd8;

    localparam logic [4:0] MUL_END  = 5'd16;
    localparam logic [4:0] SQRT_END = 5'd16;
    localparam logic [4:0] DIV_END  = 5'd30;
    localparam logic [4:0] ROT_END  = 5'd15;

    logic [2:0]         state_reg;
    logic [2:0]         job_reg;
    logic [4:0]         cnt_reg;

    logic signed [15:0] mx_reg;
    logic signed [15:0] my_reg;
    logic signed [15:0] mz_reg;
    logic signed [15:0] px_reg;
    logic signed [15:0] py_reg;
    logic signed [15:0] pz_reg;
    logic               found_reg;

    logic signed [35:0] acc_reg [9];
    logic signed [33:0] prod_reg;
    logic [3:0]         ptgt_reg;
    logic               psub_reg;
    logic               pvld_reg;

    logic [33:0]        sq_src_reg;
    logic [18:0]        sq_rem_reg;
    logic [16:0]        sq_root_reg;

    logic [31:0]        dv_den_reg;
    logic [31:0]        dv_rem_reg;
    logic [30:0]        dv_quo_reg;
    logic               dv_lsb_reg;
    logic               zneg_reg;

    logic signed [35:0] cx_reg;
    logic signed [35:0] cy_reg;
    logic signed [16:0] cz_reg;
    logic               dneg_reg;

    logic [16:0]        trans_reg;
    logic [15:0]        phi_reg;
    logic [15:0]        alpha_reg;
    logic [15:0]        pmag_reg;
    logic [15:0]        mmag_reg;
    logic signed [15:0] pcos_reg;
    logic signed [15:0] mcos_reg;

    logic               ov_reg;
    logic [16:0]        o_trans_reg;
    logic [15:0]        o_phi_reg;
    logic [15:0]        o_alpha_reg;
    logic               o_abad_reg;
    logic               o_found_reg;
    logic [15:0]        o_pmag_reg;
    logic signed [15:0] o_pcos_reg;
    logic [15:0]        o_mmag_reg;
    logic signed [15:0] o_mcos_reg;
    logic               o_pbad_reg;

    logic signed [35:0] mu_sq;
    logic signed [35:0] p_sq;
    logic               ang_bad;
    logic               pol_bad;

    logic signed [16:0] ex;
    logic signed [16:0] ey;
    logic signed [16:0] ez;
    logic signed [16:0] fx;
    logic signed [16:0] fy;
    logic signed [16:0] fz;
    logic signed [16:0] gx;
    logic signed [16:0] gy;
    logic signed [16:0] op_a;
    logic signed [16:0] op_b;
    logic [3:0]         op_tgt;
    logic               op_sub;

    logic [20:0]        sq_sh;
    logic [20:0]        sq_trial;
    logic               sq_ge;
    logic [18:0]        sq_rem_nx;
    logic [16:0]        sq_root_nx;
    logic [17:0]        sq_rnd;
    logic [15:0]        cos_n;
    logic signed [15:0] cos_val;

    logic [32:0]        dv_sh;
    logic               dv_ge;
    logic [31:0]        dv_rem_nx;
    logic [30:0]        dv_quo_nx;

    logic signed [35:0] cm;
    logic signed [35:0] sx;
    logic signed [35:0] sy;
    logic signed [35:0] cx_nx;
    logic signed [35:0] cy_nx;
    logic signed [16:0] cz_nx;
    logic signed [16:0] zc;
    logic [15:0]        ang_res;
    logic signed [35:0] dot_sel;
    logic signed [35:0] cr_sel;
    logic               out_free;

    // event-level sums and zero checks
    assign mu_sq   = acc_reg[A_MUT] + acc_reg[A_MUZ];
    assign p_sq    = acc_reg[A_PT] + acc_reg[A_PZ];
    assign ang_bad = (acc_reg[A_MUT] == 0) || (acc_reg[A_PT] == 0) || (acc_reg[A_DPT] == 0);
    assign pol_bad = (mu_sq == 0) || (p_sq == 0);

    assign evt_pop  = (state_reg == ST_IDLE) && evt_valid;
    assign out_free = !ov_reg || !out_stall;

    // product schedule
    assign ex = 17'(mx_reg);
    assign ey = 17'(my_reg);
    assign ez = 17'(mz_reg);
    assign fx = 17'(px_reg);
    assign fy = 17'(py_reg);
    assign fz = 17'(pz_reg);
    assign gx = ex + fx;
    assign gy = ey + fy;

    always_comb
    begin
        case (cnt_reg[3:0])
            4'd0:    begin op_a = ex; op_b = ex; op_tgt = A_MUT;  op_sub = 1'b0; end
            4'd1:    begin op_a = ey; op_b = ey; op_tgt = A_MUT;  op_sub = 1'b0; end
            4'd2:    begin op_a = ez; op_b = ez; op_tgt = A_MUZ;  op_sub = 1'b0; end
            4'd3:    begin op_a = fx; op_b = fx; op_tgt = A_PT;   op_sub = 1'b0; end
            4'd4:    begin op_a = fy; op_b = fy; op_tgt = A_PT;   op_sub = 1'b0; end
            4'd5:    begin op_a = fz; op_b = fz; op_tgt = A_PZ;   op_sub = 1'b0; end
            4'd6:    begin op_a = gx; op_b = gx; op_tgt = A_DPT;  op_sub = 1'b0; end
            4'd7:    begin op_a = gy; op_b = gy; op_tgt = A_DPT;  op_sub = 1'b0; end
            4'd8:    begin op_a = ex; op_b = fx; op_tgt = A_DOT1; op_sub = 1'b1; end
            4'd9:    begin op_a = ey; op_b = fy; op_tgt = A_DOT1; op_sub = 1'b1; end
            4'd10:   begin op_a = ey; op_b = fx; op_tgt = A_CR1;  op_sub = 1'b0; end
            4'd11:   begin op_a = ex; op_b = fy; op_tgt = A_CR1;  op_sub = 1'b1; end
            4'd12:   begin op_a = ex; op_b = gx; op_tgt = A_DOT2; op_sub = 1'b1; end
            4'd13:   begin op_a = ey; op_b = gy; op_tgt = A_DOT2; op_sub = 1'b1; end
            4'd14:   begin op_a = ey; op_b = gx; op_tgt = A_CR2;  op_sub = 1'b0; end
            default: begin op_a = ex; op_b = gy; op_tgt = A_CR2;  op_sub = 1'b1; end
        endcase
    end

    // one square root step, two radicand bits per cycle
    always_comb
    begin
        sq_sh    = {sq_rem_reg, sq_src_reg[33:32]};
        sq_trial = {2'b00, sq_root_reg, 2'b01};
        sq_ge    = (sq_sh >= sq_trial);
        if (sq_ge)
        begin
            sq_rem_nx  = 19'(sq_sh - sq_trial);
            sq_root_nx = {sq_root_reg[15:0], 1'b1};
        end
        else
        begin
            sq_rem_nx  = 19'(sq_sh);
            sq_root_nx = {sq_root_reg[15:0], 1'b0};
        end
        sq_rnd  = (sq_rem_nx > {2'b00, sq_root_nx}) ? 18'(sq_root_nx) + 18'd1 : 18'(sq_root_nx);
        cos_n   = 16'((17'(sq_root_nx) + 17'd1) >> 1);
        cos_val = zneg_reg ? -$signed(cos_n) : $signed(cos_n);
    end

    // one restoring divide step
    always_comb
    begin
        dv_sh = {dv_rem_reg, dv_lsb_reg};
        dv_ge = (dv_sh >= {1'b0, dv_den_reg});
        dv_rem_nx = dv_ge ? 32'(dv_sh - {1'b0, dv_den_reg}) : 32'(dv_sh);
        dv_quo_nx = {dv_quo_reg[29:0], dv_ge};
    end

    // one cordic vectoring step and the final angle
    always_comb
    begin
        cm = (cx_reg > cy_reg) ? cx_reg : cy_reg;
        sx = cx_reg >>> cnt_reg[3:0];
        sy = (cy_reg >= 0) ? (cy_reg >>> cnt_reg[3:0]) : -((-cy_reg) >>> cnt_reg[3:0]);
        if (cy_reg > 0)
        begin
            cx_nx = cx_reg + sy;
            cy_nx = cy_reg - sx;
            cz_nx = cz_reg + 17'(step_angle(cnt_reg[3:0]));
        end
        else
        begin
            cx_nx = cx_reg - sy;
            cy_nx = cy_reg + sx;
            cz_nx = cz_reg - 17'(step_angle(cnt_reg[3:0]));
        end
        if (cz_reg < 0)
        begin
            zc = '0;
        end
        else if (cz_reg > 17'sd16384)
        begin
            zc = 17'sd16384;
        end
        else
        begin
            zc = cz_reg;
        end
        ang_res = dneg_reg ? 16'(17'sd32768 - zc) : 16'(zc);
        dot_sel = (job_reg == J_PHI) ? acc_reg[A_DOT1] : acc_reg[A_DOT2];
        cr_sel  = (job_reg == J_PHI) ? acc_reg[A_CR1] : acc_reg[A_CR2];
    end

    // sequencer and datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            job_reg   <= J_DPT;
            cnt_reg   <= '0;
            pvld_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            // product pipeline
            if (pvld_reg)
            begin
                acc_reg[ptgt_reg] <= psub_reg ? acc_reg[ptgt_reg] - 36'(prod_reg)
                                              : acc_reg[ptgt_reg] + 36'(prod_reg);
            end
            pvld_reg <= (state_reg == ST_MUL) && (cnt_reg != MUL_END);

            // output slot drains
            if (ov_reg && !out_stall && state_reg != ST_FIN)
            begin
                ov_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (evt_valid)
                    begin
                        mx_reg    <= evt_data.mu_x;
                        my_reg    <= evt_data.mu_y;
                        mz_reg    <= evt_data.mu_z;
                        px_reg    <= evt_data.ld_x;
                        py_reg    <= evt_data.ld_y;
                        pz_reg    <= evt_data.ld_z;
                        found_reg <= evt_data.found;
                        for (int i = 0; i < 9; i++)
                        begin
                            acc_reg[i] <= '0;
                        end
                        cnt_reg   <= '0;
                        job_reg   <= J_DPT;
                        state_reg <= ST_MUL;
                    end
                end

                ST_MUL:
                begin
                    if (cnt_reg == MUL_END)
                    begin
                        state_reg <= ST_DISP;
                    end
                    else
                    begin
                        prod_reg <= op_a * op_b;
                        ptgt_reg <= op_tgt;
                        psub_reg <= op_sub;
                        cnt_reg  <= cnt_reg + 5'd1;
                    end
                end

                ST_DISP:
                begin
                    cnt_reg     <= '0;
                    sq_rem_reg  <= '0;
                    sq_root_reg <= '0;
                    case (job_reg)
                        J_DPT:
                        begin
                            sq_src_reg <= 34'(acc_reg[A_DPT]);
                            state_reg  <= ST_SQRT;
                        end
                        J_PMAG:
                        begin
                            sq_src_reg <= 34'(p_sq);
                            state_reg  <= ST_SQRT;
                        end
                        J_MMAG:
                        begin
                            sq_src_reg <= 34'(mu_sq);
                            state_reg  <= ST_SQRT;
                        end
                        J_PCOS, J_MCOS:
                        begin
                            if (pol_bad)
                            begin
                                if (job_reg == J_PCOS)
                                begin
                                    pcos_reg <= '0;
                                end
                                else
                                begin
                                    mcos_reg <= '0;
                                end
                                job_reg <= job_reg + 3'd1;
                            end
                            else
                            begin
                                dv_quo_reg <= '0;
                                if (job_reg == J_PCOS)
                                begin
                                    dv_den_reg <= 32'(p_sq);
                                    dv_rem_reg <= 32'(acc_reg[A_PZ] >>> 1);
                                    dv_lsb_reg <= acc_reg[A_PZ][0];
                                    zneg_reg   <= pz_reg[15];
                                end
                                else
                                begin
                                    dv_den_reg <= 32'(mu_sq);
                                    dv_rem_reg <= 32'(acc_reg[A_MUZ] >>> 1);
                                    dv_lsb_reg <= acc_reg[A_MUZ][0];
                                    zneg_reg   <= mz_reg[15];
                                end
                                state_reg <= ST_DIV;
                            end
                        end
                        J_PHI, J_ALPHA:
                        begin
                            if (ang_bad || (dot_sel == 0 && cr_sel == 0))
                            begin
                                if (job_reg == J_PHI)
                                begin
                                    phi_reg <= '0;
                                end
                                else
                                begin
                                    alpha_reg <= '0;
                                end
                                job_reg <= job_reg + 3'd1;
                            end
                            else
                            begin
                                cx_reg    <= (dot_sel < 0) ? -dot_sel : dot_sel;
                                cy_reg    <= (cr_sel < 0) ? -cr_sel : cr_sel;
                                dneg_reg  <= (dot_sel < 0);
                                state_reg <= ST_NORM;
                            end
                        end
                        default:
                        begin
                            state_reg <= ST_FIN;
                        end
                    endcase
                end

                ST_SQRT:
                begin
                    sq_rem_reg  <= sq_rem_nx;
                    sq_root_reg <= sq_root_nx;
                    sq_src_reg  <= {sq_src_reg[31:0], 2'b00};
                    cnt_reg     <= cnt_reg + 5'd1;
                    if (cnt_reg == SQRT_END)
                    begin
                        case (job_reg)
                            J_DPT:
                                trans_reg <= (sq_rnd > 18'd131071) ? 17'd131071 : 17'(sq_rnd);
                            J_PMAG:
                                pmag_reg <= (sq_rnd > 18'd65535) ? 16'd65535 : 16'(sq_rnd);
                            J_MMAG:
                                mmag_reg <= (sq_rnd > 18'd65535) ? 16'd65535 : 16'(sq_rnd);
                            J_PCOS:
                                pcos_reg <= cos_val;
                            default:
                                mcos_reg <= cos_val;
                        endcase
                        job_reg   <= job_reg + 3'd1;
                        state_reg <= ST_DISP;
                    end
                end

                ST_DIV:
                begin
                    dv_rem_reg <= dv_rem_nx;
                    dv_quo_reg <= dv_quo_nx;
                    dv_lsb_reg <= 1'b0;
                    if (cnt_reg == DIV_END)
                    begin
                        // the square root of the quotient gives twice the cosine
                        sq_src_reg  <= {3'b000, dv_quo_nx};
                        sq_rem_reg  <= '0;
                        sq_root_reg <= '0;
                        cnt_reg     <= '0;
                        state_reg   <= ST_SQRT;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end

                ST_NORM:
                begin
                    if (cm < (36'sd1 <<< 30))
                    begin
                        cx_reg <= cx_reg <<< 1;
                        cy_reg <= cy_reg <<< 1;
                    end
                    else if (cm >= (36'sd1 <<< 31))
                    begin
                        cx_reg <= cx_reg >>> 1;
                        cy_reg <= cy_reg >>> 1;
                    end
                    else
                    begin
                        cz_reg    <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_ROT;
                    end
                end

                ST_ROT:
                begin
                    if (cy_reg == 0 || cnt_reg == ROT_END)
                    begin
                        if (job_reg == J_PHI)
                        begin
                            phi_reg <= ang_res;
                        end
                        else
                        begin
                            alpha_reg <= ang_res;
                        end
                        job_reg   <= job_reg + 3'd1;
                        state_reg <= ST_DISP;
                    end
                    else
                    begin
                        cx_reg  <= cx_nx;
                        cy_reg  <= cy_nx;
                        cz_reg  <= cz_nx;
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end

                default:
                begin
                    // result waits until the output register is free
                    if (out_free)
                    begin
                        ov_reg      <= 1'b1;
                        o_trans_reg <= trans_reg;
                        o_phi_reg   <= phi_reg;
                        o_alpha_reg <= alpha_reg;
                        o_abad_reg  <= ang_bad;
                        o_found_reg <= found_reg;
                        o_pmag_reg  <= pmag_reg;
                        o_pcos_reg  <= pcos_reg;
                        o_mmag_reg  <= mmag_reg;
                        o_mcos_reg  <= mcos_reg;
                        o_pbad_reg  <= pol_bad;
                        state_reg   <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    // result word
    assign out_valid            = ov_reg;
    assign transverse_imbalance = o_trans_reg;
    assign phi_t_angle          = o_phi_reg;
    assign alpha_t_angle        = o_alpha_reg;
    assign angle_invalid        = o_abad_reg;
    assign proton_found         = o_found_reg;
    assign proton_magnitude     = o_pmag_reg;
    assign proton_cos_polar     = o_pcos_reg;
    assign muon_magnitude       = o_mmag_reg;
    assign muon_cos_polar       = o_mcos_reg;
    assign polar_invalid        = o_pbad_reg;

endmodule
`default_nettype wire

// ----- sv/leading_proton_stv_calculator_unit.sv -----
// top level of the leading-proton transverse imbalance calculator
`default_nettype none
// The front end takes one input word per cycle, unless it stalls, through a
// two-stage pipeline (code compare, then component squares and the running
// maximum) and closes an event on the word marked last. Closed events wait in
// a two-entry queue. The back end works on one event at a time with a single
// 17x17 multiplier, a two-bit-per-cycle square root unit, a one-bit-per-cycle
// divider and a one-step-per-cycle cordic: products, then the transverse
// imbalance, the magnitudes, the cosines and the angles (dispatch, normalize,
// rotate). The front only stalls when both queue entries are full and a last
// word is in its second stage.
module leading_proton_stv_calculator_unit
    import lpstv_pkg::*;
#(
    parameter int MOMENTUM_BITS = MOMENTUM_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic signed [31:0] cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               mode,
    input  logic signed [31:0] pdg_code,
    input  logic signed [15:0] mom_x,
    input  logic signed [15:0] mom_y,
    input  logic signed [15:0] mom_z,
    input  logic               last,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [16:0]        transverse_imbalance,
    output logic [15:0]        phi_t_angle,
    output logic [15:0]        alpha_t_angle,
    output logic               angle_invalid,
    output logic               proton_found,
    output logic [15:0]        proton_magnitude,
    output logic signed [15:0] proton_cos_polar,
    output logic [15:0]        muon_magnitude,
    output logic signed [15:0] muon_cos_polar,
    output logic               polar_invalid
);

    logic push_valid;
    logic push_ready;
    evt_t push_data;
    logic pop_valid;
    logic pop_ready;
    evt_t pop_data;

    // word intake and leading particle selection
    lpstv_front #(
        .MOMENTUM_BITS(MOMENTUM_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .pdg_code   (pdg_code),
        .mom_x      (mom_x),
        .mom_y      (mom_y),
        .mom_z      (mom_z),
        .last       (last),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // closed events
    lpstv_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // kinematics
    lpstv_back u_back (
        .clk                  (clk),
        .rst_n                (rst_n),
        .evt_valid            (pop_valid),
        .evt_pop              (pop_ready),
        .evt_data             (pop_data),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .transverse_imbalance (transverse_imbalance),
        .phi_t_angle          (phi_t_angle),
        .alpha_t_angle        (alpha_t_angle),
        .angle_invalid        (angle_invalid),
        .proton_found         (proton_found),
        .proton_magnitude     (proton_magnitude),
        .proton_cos_polar     (proton_cos_polar),
        .muon_magnitude       (muon_magnitude),
        .muon_cos_polar       (muon_cos_polar),
        .polar_invalid        (polar_invalid)
    );

    // degenerate transverse vectors give zero angles
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && angle_invalid |-> phi_t_angle == 16'd0 && alpha_t_angle == 16'd0)
        else $error("angles not zero on invalid transverse vector");

    // zero magnitudes give zero cosines
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && polar_invalid |-> proton_cos_polar == 16'sd0 && muon_cos_polar == 16'sd0)
        else $error("cosines not zero on zero magnitude");

    // angles stay within pi
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> phi_t_angle <= 16'd32768 && alpha_t_angle <= 16'd32768)
        else $error("angle beyond pi");

    // cosines stay within one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> proton_cos_polar <= 16'sd16384 && proton_cos_polar >= -16'sd16384
                   && muon_cos_polar <= 16'sd16384 && muon_cos_polar >= -16'sd16384)
        else $error("cosine beyond one");

endmodule
`default_nettype wire
